[src/gwp_pkg.sv]
// ----------------------------------------------------------------------------
// gwp_pkg: shared constants and types for the G-code word parser
// Field widths, character codes, output packing, state encodings and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gwp_pkg;

  // Number format
  localparam int FRAC_DIGITS_MAX = 8;
  localparam int INT_BITS        = 23;
  localparam int FRAC_BITS       = 16;

  // Derived widths
  localparam int LETTER_W = 5;
  localparam int CNT_W    = $clog2(FRAC_DIGITS_MAX + 1);
  localparam int FRAC_W   = $clog2(10 ** FRAC_DIGITS_MAX);
  localparam int POW_W    = $clog2(10 ** FRAC_DIGITS_MAX + 1);
  localparam int QUO_W    = FRAC_BITS + 1;
  localparam int DVD_W    = FRAC_W + FRAC_BITS + 1;
  localparam int QCNT_W   = $clog2(QUO_W + 1);
  localparam int MAG_W    = INT_BITS + FRAC_BITS;
  localparam int VAL_W    = MAG_W + 1;

  // Result tdata packing, lowest bit first
  localparam int LETTER_LSB = 0;
  localparam int NEG_BIT    = LETTER_LSB + LETTER_W;
  localparam int INT_LSB    = NEG_BIT + 1;
  localparam int FRAC_LSB   = INT_LSB + INT_BITS;
  localparam int CNT_LSB    = FRAC_LSB + FRAC_W;
  localparam int VAL_LSB    = CNT_LSB + CNT_W;
  localparam int OUT_BITS   = VAL_LSB + VAL_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Result tuser packing
  localparam int USER_HAS_NUM = 0;
  localparam int USER_OVF     = 1;
  localparam int OUT_USER_W   = 2;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;

  typedef logic [LETTER_W-1:0]   letter_t;
  typedef logic [INT_BITS-1:0]   int_t;
  typedef logic [INT_BITS+3:0]   intx_t;
  typedef logic [FRAC_W-1:0]     frac_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [POW_W-1:0]      pow_t;
  typedef logic [POW_W:0]        powx_t;
  typedef logic [DVD_W-1:0]      dvd_t;
  typedef logic [QUO_W-1:0]      quo_t;
  typedef logic [QCNT_W-1:0]     qcnt_t;
  typedef logic [MAG_W-1:0]      mag_t;
  typedef logic [MAG_W:0]        magx_t;
  typedef logic [VAL_W-1:0]      val_t;
  typedef logic [OUT_DATA_W-1:0] out_data_t;

  // Parser phase
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_LEAD   = 5'b00010,
    PH_SIGNED = 5'b00100,
    PH_INT    = 5'b01000,
    PH_FRAC   = 5'b10000
  } phase_t;

  // Controller states
  typedef enum logic [4:0] {
    ST_ACCEPT = 5'b00001,
    ST_START  = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_SUM    = 5'b01000,
    ST_LOAD   = 5'b10000
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic cap_second;
    logic div_start;
    logic sum_en;
    logic load_out;
  } gwp_cmd_t;

  typedef struct packed {
    logic emit;
    logic second;
    logic out_free;
  } gwp_sts_t;

endpackage

[src/gwp_div.sv]
// ----------------------------------------------------------------------------
// gwp_div: restoring divider for the fraction scaling
// One quotient bit per cycle. The upper dividend bits are known to lie below
// the divisor, so only the low QUO_W bits need a step each.
// ----------------------------------------------------------------------------
module gwp_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  gwp_pkg::dvd_t dividend,
  input  gwp_pkg::pow_t divisor,
  output logic          done,
  output gwp_pkg::quo_t quotient
);

  gwp_pkg::pow_t  rem_r, rem_nxt;
  gwp_pkg::pow_t  dvs_r;
  gwp_pkg::quo_t  low_r, low_nxt;
  gwp_pkg::quo_t  quo_r, quo_nxt;
  gwp_pkg::qcnt_t cnt_r, cnt_nxt;
  logic           run_r, run_nxt;
  gwp_pkg::powx_t trial;
  gwp_pkg::powx_t diff;

  // one step of the shift/subtract
  always_comb begin
    trial   = {rem_r, low_r[gwp_pkg::QUO_W-1]};
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = rem_r;
    low_nxt = low_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (start) begin
      rem_nxt = gwp_pkg::pow_t'(dividend[gwp_pkg::DVD_W-1:gwp_pkg::QUO_W]);
      low_nxt = dividend[gwp_pkg::QUO_W-1:0];
      quo_nxt = '0;
      cnt_nxt = gwp_pkg::qcnt_t'(gwp_pkg::QUO_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (cnt_r != '0) begin
        if (trial >= {1'b0, dvs_r}) begin
          rem_nxt = diff[gwp_pkg::POW_W-1:0];
          quo_nxt = {quo_r[gwp_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[gwp_pkg::POW_W-1:0];
          quo_nxt = {quo_r[gwp_pkg::QUO_W-2:0], 1'b0};
        end
        low_nxt = {low_r[gwp_pkg::QUO_W-2:0], 1'b0};
        cnt_nxt = cnt_r - gwp_pkg::qcnt_t'(1);
      end else begin
        run_nxt = 1'b0;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = run_r && (cnt_r == '0);
  assign quotient = quo_r;

endmodule

[src/gwp_dpath.sv]
// ----------------------------------------------------------------------------
// gwp_dpath: character parser, word capture, value assembly, output register
// Holds the open word, snapshots a closing word, forms the Q23.16 value
// from the divider quotient and drives the result channel.
// ----------------------------------------------------------------------------
module gwp_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gwp_pkg::gwp_cmd_t                   cmd,
  output gwp_pkg::gwp_sts_t                   sts,
  input  logic [7:0]                          in_tdata,  // char_in
  input  logic                                in_tlast,  // is_last
  output gwp_pkg::dvd_t                       dividend,
  output gwp_pkg::pow_t                       divisor,
  input  gwp_pkg::quo_t                       quotient,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // word_letter, negative, int_part, frac_raw, frac_digits, value_fixed, pad
  output logic [gwp_pkg::OUT_DATA_W-1:0]      out_tdata,
  // has_number, overflow
  output logic [gwp_pkg::OUT_USER_W-1:0]      out_tuser,
  output logic                                out_tlast  // end_of_line
);

  // open word
  gwp_pkg::phase_t  phase_r, phase_nxt;
  gwp_pkg::letter_t letter_r, letter_nxt;
  logic             minus_r, minus_nxt;
  gwp_pkg::int_t    int_r, int_nxt;
  gwp_pkg::frac_t   frac_r, frac_nxt;
  gwp_pkg::cnt_t    cnt_r, cnt_nxt;
  gwp_pkg::pow_t    pow_r, pow_nxt;
  logic             digit_r, digit_nxt;
  logic             sat_r, sat_nxt;

  // captured word
  gwp_pkg::letter_t cap_letter_r;
  logic             cap_neg_r;
  gwp_pkg::int_t    cap_int_r;
  gwp_pkg::frac_t   cap_frac_r;
  gwp_pkg::cnt_t    cap_cnt_r;
  gwp_pkg::pow_t    cap_pow_r;
  logic             cap_digit_r;
  logic             cap_sat_r;
  logic             cap_eol_r;
  logic             second_r;

  gwp_pkg::mag_t    mag_r;
  gwp_pkg::magx_t   mag_full;
  gwp_pkg::val_t    val;

  gwp_pkg::out_data_t out_data_r, out_word;
  logic [gwp_pkg::OUT_USER_W-1:0] out_user_r;
  logic             out_last_r;
  logic             out_valid_r;

  logic             is_dig, is_ws, is_letter, num_phase;
  logic [3:0]       digit;
  gwp_pkg::intx_t   int_ten;
  logic             used, closing, open_after, emit, second;

  // parse one character against the open word
  always_comb begin
    is_dig    = in_tdata inside {[gwp_pkg::CH_ZERO:gwp_pkg::CH_NINE]};
    is_ws     = (in_tdata == gwp_pkg::CH_SPACE) ||
                (in_tdata inside {[gwp_pkg::CH_TAB:gwp_pkg::CH_CR]});
    is_letter = in_tdata inside {[gwp_pkg::CH_A:gwp_pkg::CH_Z]};
    num_phase = (phase_r == gwp_pkg::PH_LEAD) || (phase_r == gwp_pkg::PH_SIGNED) ||
                (phase_r == gwp_pkg::PH_INT);
    digit     = in_tdata[3:0];
    int_ten   = (gwp_pkg::intx_t'(int_r) << 3) + (gwp_pkg::intx_t'(int_r) << 1) +
                gwp_pkg::intx_t'(digit);

    phase_nxt  = phase_r;
    letter_nxt = letter_r;
    minus_nxt  = minus_r;
    int_nxt    = int_r;
    frac_nxt   = frac_r;
    cnt_nxt    = cnt_r;
    pow_nxt    = pow_r;
    digit_nxt  = digit_r;
    sat_nxt    = sat_r;
    used       = 1'b0;
    closing    = 1'b0;

    if (phase_r != gwp_pkg::PH_IDLE) begin
      if ((phase_r == gwp_pkg::PH_LEAD) && is_ws) begin
        used = 1'b1;
      end else if ((phase_r == gwp_pkg::PH_LEAD) &&
                   ((in_tdata == gwp_pkg::CH_MINUS) || (in_tdata == gwp_pkg::CH_PLUS))) begin
        used      = 1'b1;
        minus_nxt = (in_tdata == gwp_pkg::CH_MINUS);
        phase_nxt = gwp_pkg::PH_SIGNED;
      end else if (num_phase && is_dig) begin
        used      = 1'b1;
        digit_nxt = 1'b1;
        phase_nxt = gwp_pkg::PH_INT;
        if (int_ten > gwp_pkg::intx_t'({gwp_pkg::INT_BITS{1'b1}})) begin
          int_nxt = '1;
          sat_nxt = 1'b1;
        end else begin
          int_nxt = int_ten[gwp_pkg::INT_BITS-1:0];
        end
      end else if (num_phase && (in_tdata == gwp_pkg::CH_DOT)) begin
        used      = 1'b1;
        phase_nxt = gwp_pkg::PH_FRAC;
      end else if ((phase_r == gwp_pkg::PH_FRAC) && is_dig) begin
        used      = 1'b1;
        digit_nxt = 1'b1;
        // digits beyond the kept count are swallowed
        if (cnt_r < gwp_pkg::cnt_t'(gwp_pkg::FRAC_DIGITS_MAX)) begin
          frac_nxt = (frac_r << 3) + (frac_r << 1) + gwp_pkg::frac_t'(digit);
          cnt_nxt  = cnt_r + gwp_pkg::cnt_t'(1);
          pow_nxt  = (pow_r << 3) + (pow_r << 1);
        end
      end
      closing = !used;
      if (closing) begin
        phase_nxt = gwp_pkg::PH_IDLE;
      end
    end

    // a letter not taken by the open word opens a new one
    if (!used && is_letter) begin
      phase_nxt  = gwp_pkg::PH_LEAD;
      letter_nxt = gwp_pkg::letter_t'(in_tdata - gwp_pkg::CH_A);
      minus_nxt  = 1'b0;
      int_nxt    = '0;
      frac_nxt   = '0;
      cnt_nxt    = '0;
      pow_nxt    = gwp_pkg::pow_t'(1);
      digit_nxt  = 1'b0;
      sat_nxt    = 1'b0;
    end

    open_after = (phase_nxt != gwp_pkg::PH_IDLE);
    if (in_tlast) begin
      phase_nxt = gwp_pkg::PH_IDLE;
    end
    emit   = closing || (in_tlast && open_after);
    second = closing && in_tlast && open_after;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= gwp_pkg::PH_IDLE;
    end else if (cmd.accept) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      letter_r <= letter_nxt;
      minus_r  <= minus_nxt;
      int_r    <= int_nxt;
      frac_r   <= frac_nxt;
      cnt_r    <= cnt_nxt;
      pow_r    <= pow_nxt;
      digit_r  <= digit_nxt;
      sat_r    <= sat_nxt;
    end
  end

  // pending second word of a line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else if (cmd.accept && emit) begin
      second_r <= second;
    end else if (cmd.cap_second) begin
      second_r <= 1'b0;
    end
  end

  // word snapshot: the old word when it closes, else the word after the beat
  always_ff @(posedge clk) begin
    if (cmd.accept && emit) begin
      if (closing) begin
        cap_letter_r <= letter_r;
        cap_neg_r    <= minus_r;
        cap_int_r    <= int_r;
        cap_frac_r   <= frac_r;
        cap_cnt_r    <= cnt_r;
        cap_pow_r    <= pow_r;
        cap_digit_r  <= digit_r;
        cap_sat_r    <= sat_r;
      end else begin
        cap_letter_r <= letter_nxt;
        cap_neg_r    <= minus_nxt;
        cap_int_r    <= int_nxt;
        cap_frac_r   <= frac_nxt;
        cap_cnt_r    <= cnt_nxt;
        cap_pow_r    <= pow_nxt;
        cap_digit_r  <= digit_nxt;
        cap_sat_r    <= sat_nxt;
      end
      cap_eol_r <= in_tlast && !second;
    end else if (cmd.cap_second) begin
      cap_letter_r <= letter_r;
      cap_neg_r    <= minus_r;
      cap_int_r    <= int_r;
      cap_frac_r   <= frac_r;
      cap_cnt_r    <= cnt_r;
      cap_pow_r    <= pow_r;
      cap_digit_r  <= digit_r;
      cap_sat_r    <= sat_r;
      cap_eol_r    <= 1'b1;
    end
  end

  // fraction scaled by 2^FRAC_BITS, plus half the divisor for rounding
  assign dividend = gwp_pkg::dvd_t'({cap_frac_r, {gwp_pkg::FRAC_BITS{1'b0}}}) +
                    gwp_pkg::dvd_t'(cap_pow_r >> 1);
  assign divisor  = cap_pow_r;

  // magnitude with saturation
  assign mag_full = gwp_pkg::magx_t'({cap_int_r, {gwp_pkg::FRAC_BITS{1'b0}}}) +
                    gwp_pkg::magx_t'(quotient);

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      mag_r <= mag_full[gwp_pkg::MAG_W] ? '1 : mag_full[gwp_pkg::MAG_W-1:0];
    end
  end

  // sign and packing
  always_comb begin
    val = cap_neg_r ? (gwp_pkg::val_t'(0) - gwp_pkg::val_t'(mag_r)) : gwp_pkg::val_t'(mag_r);
    out_word = '0;
    out_word[gwp_pkg::LETTER_LSB +: gwp_pkg::LETTER_W] = cap_letter_r;
    out_word[gwp_pkg::NEG_BIT]                         = cap_neg_r;
    out_word[gwp_pkg::INT_LSB +: gwp_pkg::INT_BITS]    = cap_int_r;
    out_word[gwp_pkg::FRAC_LSB +: gwp_pkg::FRAC_W]     = cap_frac_r;
    out_word[gwp_pkg::CNT_LSB +: gwp_pkg::CNT_W]       = cap_cnt_r;
    out_word[gwp_pkg::VAL_LSB +: gwp_pkg::VAL_W]       = val;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r                       <= out_word;
      out_user_r[gwp_pkg::USER_HAS_NUM] <= cap_digit_r;
      out_user_r[gwp_pkg::USER_OVF]     <= cap_sat_r;
      out_last_r                       <= cap_eol_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser    = out_user_r;
  assign out_tlast    = out_last_r;

  assign sts.emit     = emit;
  assign sts.second   = second_r;
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

[src/gwp_ctrl.sv]
// ----------------------------------------------------------------------------
// gwp_ctrl: sequencing controller
// Takes characters, and for each word that closes runs the divider, the
// magnitude sum and the load into the result register.
// ----------------------------------------------------------------------------
module gwp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  gwp_pkg::gwp_sts_t  sts,
  input  logic               div_done,
  output gwp_pkg::gwp_cmd_t  cmd
);

  gwp_pkg::ctrl_state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      gwp_pkg::ST_ACCEPT: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid && sts.emit) begin
          state_nxt = gwp_pkg::ST_START;
        end
      end
      gwp_pkg::ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = gwp_pkg::ST_DIV;
      end
      gwp_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = gwp_pkg::ST_SUM;
        end
      end
      gwp_pkg::ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = gwp_pkg::ST_LOAD;
      end
      gwp_pkg::ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (sts.second) begin
            cmd.cap_second = 1'b1;
            state_nxt      = gwp_pkg::ST_START;
          end else begin
            state_nxt = gwp_pkg::ST_ACCEPT;
          end
        end
      end
      default: begin
        state_nxt = gwp_pkg::ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gwp_pkg::ST_ACCEPT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/gcode_word_parser_top.sv]
// ----------------------------------------------------------------------------
// gcode_word_parser_top: G-code word parser
// Splits a command line into letter words and delivers each with its number
// in raw decimal parts and in Q23.16 fixed point.
// ----------------------------------------------------------------------------
// Feed one character per beat, with in_tlast on the final character of the
// line. A character that does not close a word is taken without leaving the
// accept state, so such characters stream at one per cycle. After a closing
// character, in_tready stays low while the fraction is scaled: ST_START starts
// the restoring divider, ST_DIV waits while it forms the quotient bit by bit,
// ST_SUM forms the magnitude and ST_LOAD loads the result register; a line
// ending that yields two words runs these steps twice. A finished result
// waits in the output register while the next characters are taken, and
// loading a further result waits until that register is free.
module gcode_word_parser_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // char_in
  input  logic                             in_tlast,   // is_last
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // word_letter, negative, int_part, frac_raw, frac_digits, value_fixed, pad
  output logic [gwp_pkg::OUT_DATA_W-1:0]   out_tdata,
  // has_number, overflow
  output logic [gwp_pkg::OUT_USER_W-1:0]   out_tuser,
  output logic                             out_tlast   // end_of_line
);

  gwp_pkg::gwp_cmd_t cmd;
  gwp_pkg::gwp_sts_t sts;
  gwp_pkg::dvd_t     dividend;
  gwp_pkg::pow_t     divisor;
  gwp_pkg::quo_t     quotient;
  logic              div_done;

  gwp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .div_done  (div_done),
    .cmd       (cmd)
  );

  gwp_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .dividend   (dividend),
    .divisor    (divisor),
    .quotient   (quotient),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  gwp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

[src/gwp_checker.sv]
// ----------------------------------------------------------------------------
// gwp_checker: port-level assertions for the G-code word parser
// Watches result hold, reset, field consistency and input hold-off on load.
// ----------------------------------------------------------------------------
module gwp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [gwp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [gwp_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                           out_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a word without digits carries zero number fields
  a_no_number_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[gwp_pkg::USER_HAS_NUM] |->
      (out_tdata[gwp_pkg::VAL_LSB +: gwp_pkg::VAL_W] == '0) &&
      (out_tdata[gwp_pkg::INT_LSB +: gwp_pkg::INT_BITS] == '0) &&
      (out_tdata[gwp_pkg::FRAC_LSB +: gwp_pkg::FRAC_W] == '0))
    else $error("word without digits has a non-zero number");

  // saturated integer part reads as all ones
  a_ovf_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[gwp_pkg::USER_OVF] |->
      (out_tdata[gwp_pkg::INT_LSB +: gwp_pkg::INT_BITS] == '1))
    else $error("overflow flagged but integer part not saturated");

  // a new result is loaded only while input is held off
  a_load_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result loaded while characters were being taken");

endmodule

bind gcode_word_parser_top gwp_checker u_gwp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
